// ----- rtl/mss_pkg.sv -----
// Package for the motor startup sequencer: phase codes, register indexes,
// reset values and the item, state and configuration types.
// No dependencies.
`default_nettype none
package mss_pkg;

  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ALIGN = 3'd1;
  localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_AWAIT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_TIMEOUT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_LIMIT    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HANDOVER_RPM  = 8'd3;

  localparam logic [15:0] ALIGN_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] OPEN_LIMIT_RST    = 16'd2000;
  localparam logic [14:0] ANGLE_STEP_RST    = 15'd104;
  localparam logic [14:0] HANDOVER_RPM_RST  = 15'd48;

  localparam logic [3:0] STEADY_TARGET = 4'd10;
  localparam logic [3:0] STEADY_MAX    = 4'd15;

  typedef struct packed {
    logic               action;
    logic [31:0]        now_ms;
    logic signed [31:0] encoder_position;
    logic               index_seen;
    logic signed [15:0] speed_rpm;
  } tick_t;

  typedef struct packed {
    logic [15:0] align_timeout_ms;
    logic [15:0] open_loop_limit_ms;
    logic [14:0] angle_step;
    logic [14:0] handover_rpm;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [31:0]        start_stamp;
    logic [31:0]        prev_position;
    logic [3:0]         steady_run;
    logic [15:0]        angle_acc;
  } seq_state_t;

endpackage
`default_nettype wire

// ----- rtl/mss_if.sv -----
// Channel interfaces of the motor startup sequencer: tick input, result output
// and configuration write. Depends on mss_pkg.
`default_nettype none
interface mss_tick_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        now_ms;
  logic signed [31:0] encoder_position;
  logic               index_seen;
  logic signed [15:0] speed_rpm;

  modport source (output valid, action, now_ms, encoder_position, index_seen, speed_rpm,
                  input ready);
  modport sink (input valid, action, now_ms, encoder_position, index_seen, speed_rpm,
                output ready);
endinterface

interface mss_result_if;
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::PHASE_W-1:0] phase;
  logic [15:0]                 open_angle;
  logic                        done_res;

  modport source (output valid, phase, open_angle, done_res, input ready);
  modport sink (input valid, phase, open_angle, done_res, output ready);
endinterface

interface mss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mss_pkg::CFG_INDEX_W-1:0] index;
  logic [mss_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/mss_step.sv -----
// Next-state logic for one sequencer tick: phase transitions, alignment
// steadiness count, open-loop angle. Depends on mss_pkg.
`default_nettype none
module mss_step (
  input  mss_pkg::tick_t      item,
  input  mss_pkg::cfg_t       cfg,
  input  mss_pkg::seq_state_t state,
  output mss_pkg::seq_state_t state_next
);

  logic [31:0] elapsed;
  logic [3:0]  steady_inc;
  logic [16:0] speed_mag;

  assign elapsed    = item.now_ms - state.start_stamp;
  assign steady_inc = (state.steady_run < mss_pkg::STEADY_MAX) ?
                      state.steady_run + 4'd1 : state.steady_run;
  assign speed_mag  = item.speed_rpm[15] ? 17'h10000 - {1'b0, item.speed_rpm} :
                      {1'b0, item.speed_rpm};

  always_comb begin
    state_next = state;
    if (item.action) begin
      state_next.phase         = mss_pkg::PH_IDLE;
      state_next.prev_position = '0;
      state_next.steady_run    = '0;
    end else begin
      unique case (state.phase)
        mss_pkg::PH_IDLE: begin
          state_next.start_stamp   = item.now_ms;
          state_next.angle_acc     = '0;
          state_next.prev_position = '0;
          state_next.steady_run    = '0;
          state_next.phase         = mss_pkg::PH_ALIGN;
        end
        mss_pkg::PH_ALIGN: begin
          if (item.encoder_position == state.prev_position) begin
            state_next.steady_run = steady_inc;
            if (steady_inc >= mss_pkg::STEADY_TARGET) begin
              state_next.phase = mss_pkg::PH_OPEN;
            end
          end else begin
            state_next.steady_run = '0;
          end
          state_next.prev_position = item.encoder_position;
          if (elapsed >= {16'd0, cfg.align_timeout_ms}) begin
            state_next.phase = mss_pkg::PH_OPEN;
          end
        end
        mss_pkg::PH_OPEN: begin
          if (elapsed >= {16'd0, cfg.open_loop_limit_ms} || item.index_seen) begin
            state_next.phase = mss_pkg::PH_AWAIT;
          end else begin
            state_next.angle_acc = state.angle_acc + {1'b0, cfg.angle_step};
          end
        end
        mss_pkg::PH_AWAIT: begin
          if (speed_mag >= {2'd0, cfg.handover_rpm}) begin
            state_next.phase = mss_pkg::PH_DONE;
          end
        end
        mss_pkg::PH_DONE: begin
        end
        default: begin
          state_next.phase         = mss_pkg::PH_IDLE;
          state_next.prev_position = '0;
          state_next.steady_run    = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/motor_startup_sequencer_core.sv -----
// Top level of the motor startup sequencer: input register, sequencer state,
// result register and configuration registers. Depends on mss_pkg, mss_if, mss_step.
//
//   channel  modport  transaction
//   tick     sink     one control tick or a reset request
//   result   source   phase, open_angle, done_res after the tick
//   cfg      sink     register write, index and data
//
// A tick is held in the input register, then its result in the result register; one
// tick per cycle is sustained while the result is not stalled, set by the single state
// update between input and result register. rst clears the sequencer state and both
// valid flags and loads the configuration reset values. A stalled result holds; the
// input register accepts while it is empty or while the result is free to move.
`default_nettype none
module motor_startup_sequencer_core (
  input  wire          clk,
  input  wire          rst,
  mss_tick_if.sink     tick,
  mss_result_if.source result,
  mss_cfg_if.sink      cfg
);

  logic                s1_valid;
  mss_pkg::tick_t      s1_item;
  logic                s1_advance;
  mss_pkg::cfg_t       cfg_regs;
  mss_pkg::seq_state_t state;
  mss_pkg::seq_state_t state_next;
  logic                out_valid;
  logic [mss_pkg::PHASE_W-1:0] out_phase;
  logic [15:0]         out_angle;

  assign s1_advance = s1_valid && (!out_valid || result.ready);
  assign tick.ready = !s1_valid || s1_advance;
  assign cfg.ready  = 1'b1;

  mss_step u_step (
    .item       (s1_item),
    .cfg        (cfg_regs),
    .state      (state),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.align_timeout_ms   <= mss_pkg::ALIGN_TIMEOUT_RST;
      cfg_regs.open_loop_limit_ms <= mss_pkg::OPEN_LIMIT_RST;
      cfg_regs.angle_step         <= mss_pkg::ANGLE_STEP_RST;
      cfg_regs.handover_rpm       <= mss_pkg::HANDOVER_RPM_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        mss_pkg::REG_ALIGN_TIMEOUT: cfg_regs.align_timeout_ms   <= cfg.data;
        mss_pkg::REG_OPEN_LIMIT:    cfg_regs.open_loop_limit_ms <= cfg.data;
        mss_pkg::REG_ANGLE_STEP:    cfg_regs.angle_step         <= cfg.data[14:0];
        mss_pkg::REG_HANDOVER_RPM:  cfg_regs.handover_rpm       <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item.action           <= tick.action;
      s1_item.now_ms           <= tick.now_ms;
      s1_item.encoder_position <= tick.encoder_position;
      s1_item.index_seen       <= tick.index_seen;
      s1_item.speed_rpm        <= tick.speed_rpm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_phase <= state_next.phase;
      out_angle <= state_next.angle_acc;
    end
  end

  assign result.valid      = out_valid;
  assign result.phase      = out_phase;
  assign result.open_angle = out_angle;
  assign result.done_res   = (out_phase == mss_pkg::PH_DONE);

endmodule
`default_nettype wire

// ----- rtl/mss_checker.sv -----
// Port-level checks on the motor startup sequencer, bound to the top level.
// Depends on mss_pkg and motor_startup_sequencer_core.
`default_nettype none
module mss_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        res_valid,
  input wire                        res_ready,
  input wire [mss_pkg::PHASE_W-1:0] res_phase,
  input wire [15:0]                 res_angle,
  input wire                        res_done
);

  a_done_matches_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_done == (res_phase == mss_pkg::PH_DONE)))
    else $error("done_res disagrees with phase");

  a_phase_defined: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_phase <= mss_pkg::PH_DONE))
    else $error("undefined phase code on result");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_phase) && $stable(res_angle))
    else $error("stalled result changed");

endmodule

bind motor_startup_sequencer_core mss_checker u_mss_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_phase (result.phase),
  .res_angle (result.open_angle),
  .res_done  (result.done_res)
);
`default_nettype wire

// ----- verif/motor_startup_sequencer_core_test.sv -----
// Self-checking testbench for motor_startup_sequencer_core: drives ticks and register
// writes, predicts phase, open_angle and done_res per tick and checks every result.
// Depends on mss_pkg, mss_if and the core RTL.
module motor_startup_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PER_MIX = 300;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  localparam logic [mss_pkg::CFG_INDEX_W-1:0] REG_SPARE = 8'hFF;

  typedef struct packed {
    logic [mss_pkg::PHASE_W-1:0] phase;
    logic [15:0]                 open_angle;
    logic                        done_res;
  } startup_view_t;

  logic clk;
  logic rst;

  mss_tick_if   tick_if();
  mss_result_if result_if();
  mss_cfg_if    cfg_if();

  motor_startup_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  mss_pkg::cfg_t               cfg_model;
  logic [mss_pkg::PHASE_W-1:0] seq_phase;
  logic [31:0]                 seq_start;
  logic [31:0]                 seq_prev_pos;
  logic [3:0]                  seq_steady;
  logic [15:0]                 seq_angle;

  startup_view_t expected_views[$];

  int src_idle_pct;
  int sink_stall_pct;
  int fail_count;
  int ticks_sent;
  int views_checked;
  int writes_done;

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(RUN_LIMIT_NS);
    $display("[motor_startup_sequencer_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    result_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic startup_view_t advance_sequencer(input mss_pkg::tick_t t);
    logic [31:0]   elapsed;
    logic [16:0]   speed_mag;
    startup_view_t view;
    elapsed = t.now_ms - seq_start;
    if (t.action == ACT_RESTART) begin
      seq_phase = mss_pkg::PH_IDLE;
      seq_prev_pos = '0;
      seq_steady = '0;
    end else begin
      case (seq_phase)
        mss_pkg::PH_IDLE: begin
          seq_start = t.now_ms;
          seq_angle = '0;
          seq_prev_pos = '0;
          seq_steady = '0;
          seq_phase = mss_pkg::PH_ALIGN;
        end
        mss_pkg::PH_ALIGN: begin
          if (t.encoder_position == seq_prev_pos) begin
            if (seq_steady < mss_pkg::STEADY_MAX) seq_steady = seq_steady + 4'd1;
            if (seq_steady >= mss_pkg::STEADY_TARGET) seq_phase = mss_pkg::PH_OPEN;
          end else begin
            seq_steady = '0;
          end
          seq_prev_pos = t.encoder_position;
          if (elapsed >= {16'd0, cfg_model.align_timeout_ms}) seq_phase = mss_pkg::PH_OPEN;
        end
        mss_pkg::PH_OPEN: begin
          if (elapsed >= {16'd0, cfg_model.open_loop_limit_ms} || t.index_seen) begin
            seq_phase = mss_pkg::PH_AWAIT;
          end else begin
            seq_angle = seq_angle + {1'b0, cfg_model.angle_step};
          end
        end
        mss_pkg::PH_AWAIT: begin
          speed_mag = t.speed_rpm[15] ? 17'h10000 - {1'b0, t.speed_rpm}
                                      : {1'b0, t.speed_rpm};
          if (speed_mag >= {2'b0, cfg_model.handover_rpm}) seq_phase = mss_pkg::PH_DONE;
        end
        mss_pkg::PH_DONE: begin
        end
        default: begin
          seq_phase = mss_pkg::PH_IDLE;
          seq_prev_pos = '0;
          seq_steady = '0;
        end
      endcase
    end
    view.phase = seq_phase;
    view.open_angle = seq_angle;
    view.done_res = (seq_phase == mss_pkg::PH_DONE);
    return view;
  endfunction

  always @(posedge clk) begin : check_views
    startup_view_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_views.size() == 0) begin
        $error("result transaction with nothing expected: phase %0d", result_if.phase);
        fail_count++;
      end else begin
        want = expected_views.pop_front();
        views_checked++;
        if (result_if.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, result_if.phase);
          fail_count++;
        end
        if (result_if.open_angle !== want.open_angle) begin
          $error("open_angle: expected %0d, got %0d", want.open_angle, result_if.open_angle);
          fail_count++;
        end
        if (result_if.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, result_if.done_res);
          fail_count++;
        end
      end
    end
  end

  function automatic mss_pkg::tick_t make_tick(input logic act, input logic [31:0] now,
                                               input logic [31:0] pos, input logic idx,
                                               input logic [15:0] spd);
    mss_pkg::tick_t t;
    t.action = act;
    t.now_ms = now;
    t.encoder_position = pos;
    t.index_seen = idx;
    t.speed_rpm = spd;
    return t;
  endfunction

  task automatic send_tick(input mss_pkg::tick_t t);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.action <= t.action;
    tick_if.now_ms <= t.now_ms;
    tick_if.encoder_position <= t.encoder_position;
    tick_if.index_seen <= t.index_seen;
    tick_if.speed_rpm <= t.speed_rpm;
    do @(posedge clk); while (!tick_if.ready);
    expected_views.push_back(advance_sequencer(t));
    ticks_sent++;
  endtask

  task automatic settle_sequencer();
    tick_if.valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      mss_pkg::REG_ALIGN_TIMEOUT: cfg_model.align_timeout_ms = value;
      mss_pkg::REG_OPEN_LIMIT:    cfg_model.open_loop_limit_ms = value;
      mss_pkg::REG_ANGLE_STEP:    cfg_model.angle_step = value[14:0];
      mss_pkg::REG_HANDOVER_RPM:  cfg_model.handover_rpm = value[14:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    writes_done++;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_speed();
    int span;
    int mag;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom);
      default: begin
        span = (cfg_model.handover_rpm > 15'd16000) ? 32767 : 2 * cfg_model.handover_rpm + 8;
        mag = $urandom_range(0, span);
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end
    endcase
  endfunction

  task automatic session_tick(input logic [31:0] now, input logic [31:0] pos,
                              input logic idx, input logic [15:0] spd);
    send_tick(make_tick(($urandom_range(0, 49) == 0) ? ACT_RESTART : ACT_TICK,
                        now, pos, idx, spd));
  endtask

  task automatic shuffle_settings();
    settle_sequencer();
    case ($urandom_range(0, 7))
      0: begin
        write_reg(mss_pkg::REG_ALIGN_TIMEOUT, 16'h0000);
        write_reg(mss_pkg::REG_OPEN_LIMIT, 16'h0000);
        write_reg(mss_pkg::REG_ANGLE_STEP, 16'h8000);
        write_reg(mss_pkg::REG_HANDOVER_RPM, 16'h8000);
      end
      1: begin
        write_reg(mss_pkg::REG_ALIGN_TIMEOUT, 16'hFFFF);
        write_reg(mss_pkg::REG_OPEN_LIMIT, 16'hFFFF);
        write_reg(mss_pkg::REG_ANGLE_STEP, 16'hFFFF);
        write_reg(mss_pkg::REG_HANDOVER_RPM, 16'hFFFF);
      end
      default: begin
        write_reg(mss_pkg::REG_ALIGN_TIMEOUT, 16'($urandom_range(0, 30)));
        write_reg(mss_pkg::REG_OPEN_LIMIT, 16'($urandom_range(0, 80)));
        write_reg(mss_pkg::REG_ANGLE_STEP, 16'($urandom));
        write_reg(mss_pkg::REG_HANDOVER_RPM,
                  16'($urandom_range(0, 300)) | {$urandom_range(0, 1) == 1, 15'd0});
      end
    endcase
  endtask

  task automatic run_startup_session();
    logic [31:0] clock_ms;
    logic [31:0] pos;
    int n;
    clock_ms = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
    if (seq_phase != mss_pkg::PH_IDLE)
      send_tick(make_tick(ACT_RESTART, $urandom, $urandom, 1'($urandom_range(0, 1)),
                          16'($urandom)));
    send_tick(make_tick(ACT_TICK, clock_ms, $urandom, 1'($urandom_range(0, 1)),
                        16'($urandom)));
    pos = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    n = 0;
    while (seq_phase == mss_pkg::PH_ALIGN && n < 40) begin
      clock_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
      if ($urandom_range(0, 5) == 0) pos = $urandom;
      session_tick(clock_ms, pos, 1'($urandom_range(0, 1)), 16'($urandom));
      n++;
    end
    n = 0;
    while (seq_phase == mss_pkg::PH_OPEN && n < 60) begin
      clock_ms += 1;
      session_tick(clock_ms, $urandom, $urandom_range(0, 24) == 0, 16'($urandom));
      n++;
    end
    n = 0;
    while (seq_phase == mss_pkg::PH_AWAIT && n < 20) begin
      clock_ms += 1;
      session_tick(clock_ms, $urandom, 1'($urandom_range(0, 1)), pick_speed());
      n++;
    end
    repeat ($urandom_range(0, 3)) begin
      clock_ms += 1;
      session_tick(clock_ms, $urandom, 1'($urandom_range(0, 1)), 16'($urandom));
    end
  endtask

  task automatic test_default_startup();
    logic [31:0] clock_ms;
    clock_ms = 32'd100;
    send_tick(make_tick(ACT_TICK, clock_ms, 32'h7FFF_FFFF, 1'b1, 16'h7FFF));
    repeat (10) begin
      clock_ms += 1;
      send_tick(make_tick(ACT_TICK, clock_ms, 32'd0, 1'b0, 16'd0));
    end
    send_tick(make_tick(ACT_TICK, clock_ms + 1, 32'hFFFF_FFFF, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, clock_ms + 2, 32'd3, 1'b1, 16'd0));
    send_tick(make_tick(ACT_TICK, clock_ms + 3, 32'd3, 1'b0, 16'd47));
    send_tick(make_tick(ACT_TICK, clock_ms + 4, 32'd3, 1'b0, 16'h8000));
    send_tick(make_tick(ACT_TICK, clock_ms + 5, 32'd3, 1'b0, 16'd0));
    send_tick(make_tick(ACT_RESTART, clock_ms + 6, 32'h8000_0000, 1'b1, 16'hFFFF));
    send_tick(make_tick(ACT_TICK, clock_ms + 7, 32'd0, 1'b0, 16'd0));
  endtask

  task automatic test_register_extremes();
    logic [31:0] clock_ms;
    settle_sequencer();
    write_reg(mss_pkg::REG_ALIGN_TIMEOUT, 16'h0000);
    write_reg(mss_pkg::REG_OPEN_LIMIT, 16'hFFFF);
    write_reg(mss_pkg::REG_ANGLE_STEP, 16'hFFFF);
    write_reg(mss_pkg::REG_HANDOVER_RPM, 16'hFFFF);
    write_reg(REG_SPARE, 16'h1234);
    send_tick(make_tick(ACT_RESTART, 32'd0, 32'd0, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'hFFFF_FFFE, 32'd0, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'hFFFF_FFFF, 32'd5, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'd0, 32'd5, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'd1, 32'd5, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'd2, 32'd5, 1'b1, 16'd0));
    send_tick(make_tick(ACT_TICK, 32'd3, 32'd5, 1'b0, 16'd32766));
    send_tick(make_tick(ACT_TICK, 32'd4, 32'd5, 1'b0, 16'd32767));

    settle_sequencer();
    write_reg(mss_pkg::REG_ALIGN_TIMEOUT, 16'd10);
    write_reg(mss_pkg::REG_OPEN_LIMIT, 16'h0000);
    write_reg(mss_pkg::REG_HANDOVER_RPM, 16'h0000);
    send_tick(make_tick(ACT_RESTART, 32'd0, 32'd0, 1'b0, 16'd0));
    clock_ms = 32'd50;
    send_tick(make_tick(ACT_TICK, clock_ms, 32'd9, 1'b0, 16'd0));
    repeat (10) begin
      clock_ms += 1;
      send_tick(make_tick(ACT_TICK, clock_ms, 32'd0, 1'b0, 16'd0));
    end
    send_tick(make_tick(ACT_TICK, clock_ms + 1, 32'd0, 1'b0, 16'd0));
    send_tick(make_tick(ACT_TICK, clock_ms + 2, 32'd0, 1'b0, 16'd0));
  endtask

  task automatic test_random_startups();
    int src_plan [4] = '{0, 72, 0, 22};
    int sink_plan [4] = '{0, 0, 72, 22};
    int goal;
    for (int mix = 0; mix < 4; mix++) begin
      src_idle_pct = src_plan[mix];
      sink_stall_pct = sink_plan[mix];
      goal = ticks_sent + RANDOM_PER_MIX;
      while (ticks_sent < goal) begin
        if ($urandom_range(0, 3) == 0) shuffle_settings();
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4))
            send_tick(make_tick(1'($urandom_range(0, 1)), $urandom, $urandom,
                                1'($urandom_range(0, 1)), 16'($urandom)));
        end else begin
          run_startup_session();
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    tick_if.valid = 1'b0;
    tick_if.action = ACT_TICK;
    tick_if.now_ms = '0;
    tick_if.encoder_position = '0;
    tick_if.index_seen = 1'b0;
    tick_if.speed_rpm = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = mss_pkg::REG_ALIGN_TIMEOUT;
    cfg_if.data = '0;
    result_if.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    cfg_model = '{mss_pkg::ALIGN_TIMEOUT_RST, mss_pkg::OPEN_LIMIT_RST,
                  mss_pkg::ANGLE_STEP_RST, mss_pkg::HANDOVER_RPM_RST};
    seq_phase = mss_pkg::PH_IDLE;
    seq_start = '0;
    seq_prev_pos = '0;
    seq_steady = '0;
    seq_angle = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_startup();
    test_register_extremes();
    test_random_startups();
    settle_sequencer();

    $display("%0d ticks sent, %0d results compared, %0d register writes", ticks_sent,
             views_checked, writes_done);
    $display("covered: default and extreme settings, all phases, four idle/stall mixes");
    if (fail_count == 0) begin
      $display("[motor_startup_sequencer_core] OK");
    end else begin
      $display("[motor_startup_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
